@@ hw/rtl/pot_average_range_tracker_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the pot average range tracker
// Concurrent checks clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POT_AVERAGE_RANGE_TRACKER_UNIT_DEFINES_SVH
`define POT_AVERAGE_RANGE_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication
`define PART_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PART_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/part_pkg.sv @@
// ----------------------------------------------------------------------------
// Pot average range tracker package
// Field widths, constants, register indexes and controller types.
// ----------------------------------------------------------------------------
`default_nettype none

package part_pkg;

   localparam int SAMPLE_W  = 10;
   localparam int VALUE_W   = 14;
   localparam int AVG_W     = 10;
   localparam int SEED_W    = 8;
   localparam int CSR_IDX_W = 8;

   localparam int VALUE_NUM = 10230;
   localparam int VALUE_OFS = 10;
   localparam int LOW_RESET = 1023;

   localparam logic [CSR_IDX_W-1:0] REG_X_LOW  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_X_HIGH = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_Y_LOW  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_Y_HIGH = 8'd3;

   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   localparam logic AXIS_X = 1'b0;
   localparam logic AXIS_Y = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED,
      ST_FETCH,
      ST_UPDATE,
      ST_AVG,
      ST_VAL_GO,
      ST_VAL_WAIT,
      ST_TRACK,
      ST_DONE
   } part_state_type;

   typedef struct packed {
      logic load_item;
      logic seed;
      logic fetch;
      logic ring_update;
      logic div_start;
      logic avg_load;
      logic value_load;
      logic track;
      logic out_load;
   } part_cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_free;
   } part_status_type;

endpackage

`default_nettype wire

@@ hw/rtl/part_ifs.sv @@
// ----------------------------------------------------------------------------
// Pot average range tracker channels
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface part_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic                          axis;
   logic [part_pkg::SAMPLE_W-1:0] sample;
   logic                          use_stored;

   modport source (output valid, output op, output axis, output sample,
                   output use_stored, input ready);
   modport sink   (input valid, input op, input axis, input sample,
                   input use_stored, output ready);
endinterface

interface part_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         axis_out;
   logic [part_pkg::VALUE_W-1:0] value;
   logic [part_pkg::VALUE_W-1:0] range_min;
   logic [part_pkg::VALUE_W-1:0] range_max;
   logic [part_pkg::VALUE_W-1:0] range_center;
   logic                         tracking;

   modport source (output valid, output axis_out, output value, output range_min,
                   output range_max, output range_center, output tracking,
                   input ready);
   modport sink   (input valid, input axis_out, input value, input range_min,
                   input range_max, input range_center, input tracking,
                   output ready);
endinterface

interface part_csr_if;
   logic                           valid;
   logic                           ready;
   logic [part_pkg::CSR_IDX_W-1:0] index;
   logic [part_pkg::SEED_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pot_average_range_tracker_unit.sv @@
// A restart word passes through the seed and done states; a sample word through
// fetch, update, average, divider start and wait (DIV_W = 14, the 10230 / average
// divider), track and done. One word in flight; the next word is accepted the
// cycle after the result registers, and done holds while the response side stalls.
// Reset: synchronous, active high; rings read as zero, ranges 1023/0, seeds 0.
// ----------------------------------------------------------------------------
// Pot average range tracker
// Per-axis moving average, reciprocal transform and min/max/center tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module pot_average_range_tracker_unit #(
   parameter int WINDOW = 8
) (
   input  wire logic   clock,
   input  wire logic   reset,
   part_req_if.sink    req_if,
   part_rsp_if.source  rsp_if,
   part_csr_if.sink    csr_if
);

   part_pkg::part_cmd_type    cmd;
   part_pkg::part_status_type status;
   logic                      req_ready;

   assign req_if.ready = req_ready;
   assign csr_if.ready = 1'b1;

   part_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_op    (req_if.op),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   part_datapath #(
      .WINDOW(WINDOW)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_if.op),
      .req_axis         (req_if.axis),
      .req_sample       (req_if.sample),
      .req_use_stored   (req_if.use_stored),
      .csr_write        (csr_if.valid),
      .csr_index        (csr_if.index),
      .csr_data         (csr_if.data),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_axis_out     (rsp_if.axis_out),
      .rsp_value        (rsp_if.value),
      .rsp_range_min    (rsp_if.range_min),
      .rsp_range_max    (rsp_if.range_max),
      .rsp_range_center (rsp_if.range_center),
      .rsp_tracking     (rsp_if.tracking)
   );

endmodule

`default_nettype wire

@@ hw/rtl/part_div.sv @@
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module part_div #(
   parameter int W = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              done,
   output logic [W-1:0]      quotient
);

   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [W:0]    shifted;
   logic [W+1:0]  diff;

   assign shifted = {rem_ff, quo_ff[W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CW'(1);
         if (!diff[W+1]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ hw/rtl/part_ctrl.sv @@
// ----------------------------------------------------------------------------
// Pot average range tracker controller
// Sequences one word at a time through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module part_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_op,
   output logic                           req_ready,
   input  wire part_pkg::part_status_type status,
   output part_pkg::part_cmd_type         cmd
);

   part_pkg::part_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         part_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_op == part_pkg::OP_RESTART) ? part_pkg::ST_SEED
                                                           : part_pkg::ST_FETCH;
            end
         end
         part_pkg::ST_SEED:     state_in = part_pkg::ST_DONE;
         part_pkg::ST_FETCH:    state_in = part_pkg::ST_UPDATE;
         part_pkg::ST_UPDATE:   state_in = part_pkg::ST_AVG;
         part_pkg::ST_AVG:      state_in = part_pkg::ST_VAL_GO;
         part_pkg::ST_VAL_GO:   state_in = part_pkg::ST_VAL_WAIT;
         part_pkg::ST_VAL_WAIT: begin
            if (status.div_done) state_in = part_pkg::ST_TRACK;
         end
         part_pkg::ST_TRACK:    state_in = part_pkg::ST_DONE;
         part_pkg::ST_DONE: begin
            if (status.out_free) state_in = part_pkg::ST_IDLE;
         end
         default:               state_in = part_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         part_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         part_pkg::ST_SEED:     cmd.seed = 1'b1;
         part_pkg::ST_FETCH:    cmd.fetch = 1'b1;
         part_pkg::ST_UPDATE:   cmd.ring_update = 1'b1;
         part_pkg::ST_AVG:      cmd.avg_load = 1'b1;
         part_pkg::ST_VAL_GO:   cmd.div_start = 1'b1;
         part_pkg::ST_VAL_WAIT: cmd.value_load = status.div_done;
         part_pkg::ST_TRACK:    cmd.track = 1'b1;
         part_pkg::ST_DONE:     cmd.out_load = status.out_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= part_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/part_datapath.sv @@
// ----------------------------------------------------------------------------
// Pot average range tracker datapath
// Sample rings, running sums, reciprocal average, divider, range tracks,
// output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pot_average_range_tracker_unit_defines.svh"

module part_datapath #(
   parameter int WINDOW = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire part_pkg::part_cmd_type         cmd,
   output part_pkg::part_status_type           status,
   input  wire logic                           req_op,
   input  wire logic                           req_axis,
   input  wire logic [part_pkg::SAMPLE_W-1:0]  req_sample,
   input  wire logic                           req_use_stored,
   input  wire logic                           csr_write,
   input  wire logic [part_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [part_pkg::SEED_W-1:0]    csr_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_axis_out,
   output logic [part_pkg::VALUE_W-1:0]        rsp_value,
   output logic [part_pkg::VALUE_W-1:0]        rsp_range_min,
   output logic [part_pkg::VALUE_W-1:0]        rsp_range_max,
   output logic [part_pkg::VALUE_W-1:0]        rsp_range_center,
   output logic                                rsp_tracking
);

   localparam int SW_  = part_pkg::SAMPLE_W;
   localparam int VW   = part_pkg::VALUE_W;
   localparam int AVW  = part_pkg::AVG_W;
   localparam int SDW  = part_pkg::SEED_W;
   localparam int SUM_W = SW_ + $clog2(WINDOW);
   localparam int DIV_W = VW;
   localparam int DEPTH = 2 * WINDOW;
   localparam int AW    = $clog2(DEPTH);
   localparam int SLW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int WCW   = $clog2(DEPTH + 1);

   // sum / WINDOW as (sum * RCP_M) >> RCP_SH, exact for every sum below 2**SUM_W
   localparam int RCP_SH = SUM_W + $clog2(WINDOW);
   localparam int RCP_M  = ((1 << RCP_SH) + WINDOW - 1) / WINDOW;
   localparam int PRD_W  = 2 * SUM_W;

   // latched word
   logic           op_ff, axis_ff, use_ff;
   logic [SW_-1:0] sample_ff;

   // seed registers
   logic [SDW-1:0] x_low_seed_ff, x_high_seed_ff, y_low_seed_ff, y_high_seed_ff;
   logic [SDW-1:0] x_low_seed_in, x_high_seed_in, y_low_seed_in, y_high_seed_in;

   // sample rings, both axes in one memory
   logic [SW_-1:0]   ring_mem [DEPTH];
   logic [DEPTH-1:0] ring_vld_ff, ring_vld_in;
   logic [SW_-1:0]   rd_data_ff;
   logic             rd_vld_ff;
   logic [AW-1:0]    addr;
   logic [SW_-1:0]   old_sample;

   logic [SLW-1:0]   slot_ff [2];
   logic [SLW-1:0]   slot_in [2];
   logic [SUM_W-1:0] sum_ff  [2];
   logic [SUM_W-1:0] sum_in  [2];

   logic [VW-1:0] low_ff    [2];
   logic [VW-1:0] low_in    [2];
   logic [VW-1:0] high_ff   [2];
   logic [VW-1:0] high_in   [2];
   logic [VW-1:0] center_ff [2];
   logic [VW-1:0] center_in [2];
   logic [VW-1:0] low_new, high_new;
   logic [VW:0]   mid_sum;

   logic [WCW-1:0] warm_ff, warm_in;
   logic           track_on_ff, track_on_in;

   logic [PRD_W-1:0] avg_prod;
   logic [AVW-1:0]   avg_raw;
   logic [AVW-1:0]   avg_ff, avg_in;
   logic [VW-1:0]    value_ff, value_in;

   logic [DIV_W-1:0] div_dividend, div_divisor, div_quotient;
   logic             div_done;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_axis_ff;
   logic [VW-1:0] out_value_ff, out_min_ff, out_max_ff, out_center_ff;
   logic          out_tracking_ff;
   logic          out_free;

   assign addr = axis_ff ? (AW'(WINDOW) + AW'(slot_ff[axis_ff])) : AW'(slot_ff[axis_ff]);
   assign old_sample = rd_vld_ff ? rd_data_ff : '0;

   assign avg_prod = PRD_W'(sum_ff[axis_ff]) * PRD_W'(RCP_M);
   assign avg_raw  = avg_prod[RCP_SH +: AVW];

   assign div_dividend = DIV_W'(part_pkg::VALUE_NUM);
   assign div_divisor  = DIV_W'(avg_ff);

   part_div #(
      .W(DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign out_free        = !rsp_valid_ff || rsp_ready;
   assign status.div_done = div_done;
   assign status.out_free = out_free;

   assign low_new  = (value_ff < low_ff[axis_ff])  ? value_ff : low_ff[axis_ff];
   assign high_new = (value_ff > high_ff[axis_ff]) ? value_ff : high_ff[axis_ff];
   assign mid_sum  = {1'b0, low_new} + {1'b0, high_new};

   always_comb begin
      x_low_seed_in  = x_low_seed_ff;
      x_high_seed_in = x_high_seed_ff;
      y_low_seed_in  = y_low_seed_ff;
      y_high_seed_in = y_high_seed_ff;
      if (csr_write) begin
         case (csr_index)
            part_pkg::REG_X_LOW:  x_low_seed_in  = csr_data;
            part_pkg::REG_X_HIGH: x_high_seed_in = csr_data;
            part_pkg::REG_Y_LOW:  y_low_seed_in  = csr_data;
            part_pkg::REG_Y_HIGH: y_high_seed_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      ring_vld_in = ring_vld_ff;
      slot_in     = slot_ff;
      sum_in      = sum_ff;
      low_in      = low_ff;
      high_in     = high_ff;
      center_in   = center_ff;
      warm_in     = warm_ff;
      track_on_in = track_on_ff;
      if (cmd.fetch && (axis_ff == part_pkg::AXIS_X)) begin
         if (warm_ff >= WCW'(DEPTH)) begin
            warm_in     = '0;
            track_on_in = 1'b1;
         end else begin
            warm_in = warm_ff + WCW'(1);
         end
      end
      if (cmd.ring_update) begin
         ring_vld_in[addr] = 1'b1;
         slot_in[axis_ff]  = (slot_ff[axis_ff] == SLW'(WINDOW - 1)) ? '0
                                                                    : slot_ff[axis_ff] + SLW'(1);
         sum_in[axis_ff]   = sum_ff[axis_ff] - SUM_W'(old_sample) + SUM_W'(sample_ff);
      end
      if (cmd.seed) begin
         if (use_ff) begin
            low_in[part_pkg::AXIS_X]  = VW'(x_low_seed_ff);
            high_in[part_pkg::AXIS_X] = VW'(x_high_seed_ff);
            low_in[part_pkg::AXIS_Y]  = VW'(y_low_seed_ff);
            high_in[part_pkg::AXIS_Y] = VW'(y_high_seed_ff);
         end else begin
            low_in[part_pkg::AXIS_X]  = VW'(part_pkg::LOW_RESET);
            high_in[part_pkg::AXIS_X] = '0;
            low_in[part_pkg::AXIS_Y]  = VW'(part_pkg::LOW_RESET);
            high_in[part_pkg::AXIS_Y] = '0;
         end
      end
      if (cmd.track && track_on_ff) begin
         low_in[axis_ff]    = low_new;
         high_in[axis_ff]   = high_new;
         center_in[axis_ff] = mid_sum[VW:1];
      end
   end

   always_comb begin
      avg_in   = avg_ff;
      value_in = value_ff;
      if (cmd.avg_load) begin
         avg_in = (avg_raw == '0) ? AVW'(1) : avg_raw;
      end
      if (cmd.value_load) begin
         value_in = div_quotient[VW-1:0] + VW'(part_pkg::VALUE_OFS);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_low_seed_ff  <= '0;
         x_high_seed_ff <= '0;
         y_low_seed_ff  <= '0;
         y_high_seed_ff <= '0;
         ring_vld_ff    <= '0;
         slot_ff        <= '{default: '0};
         sum_ff         <= '{default: '0};
         low_ff         <= '{default: VW'(part_pkg::LOW_RESET)};
         high_ff        <= '{default: '0};
         center_ff      <= '{default: '0};
         warm_ff        <= '0;
         track_on_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         x_low_seed_ff  <= x_low_seed_in;
         x_high_seed_ff <= x_high_seed_in;
         y_low_seed_ff  <= y_low_seed_in;
         y_high_seed_ff <= y_high_seed_in;
         ring_vld_ff    <= ring_vld_in;
         slot_ff        <= slot_in;
         sum_ff         <= sum_in;
         low_ff         <= low_in;
         high_ff        <= high_in;
         center_ff      <= center_in;
         warm_ff        <= warm_in;
         track_on_ff    <= track_on_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ring_update) begin
         ring_mem[addr] <= sample_ff;
      end
      if (cmd.fetch) begin
         rd_data_ff <= ring_mem[addr];
         rd_vld_ff  <= ring_vld_ff[addr];
      end
   end

   always_ff @(posedge clock) begin
      avg_ff   <= avg_in;
      value_ff <= value_in;
      if (cmd.load_item) begin
         op_ff     <= req_op;
         axis_ff   <= req_axis;
         sample_ff <= req_sample;
         use_ff    <= req_use_stored;
      end
      if (cmd.out_load) begin
         out_axis_ff     <= axis_ff;
         out_value_ff    <= (op_ff == part_pkg::OP_RESTART) ? '0 : value_ff;
         out_min_ff      <= low_ff[axis_ff];
         out_max_ff      <= high_ff[axis_ff];
         out_center_ff   <= center_ff[axis_ff];
         out_tracking_ff <= track_on_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_axis_out     = out_axis_ff;
   assign rsp_value        = out_value_ff;
   assign rsp_range_min    = out_min_ff;
   assign rsp_range_max    = out_max_ff;
   assign rsp_range_center = out_center_ff;
   assign rsp_tracking     = out_tracking_ff;

   `PART_ASSERT_NEXT(a_value_range, cmd.value_load,
      (value_ff >= VW'(20)) && (value_ff <= VW'(10240)), "value out of range")
   `PART_ASSERT_NEXT(a_avg_nonzero, cmd.avg_load, avg_ff != '0, "zero average")
   `PART_ASSERT_NEXT(a_track_sticky, track_on_ff, track_on_ff, "tracking dropped")
   `PART_ASSERT_NOW(a_out_free, cmd.out_load, out_free, "output word overwritten")

endmodule

`default_nettype wire

@@ dv/pot_average_range_tracker_unit_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pot average range tracker checker
// Watches the request, response and register channels, keeps its own copy of
// the sample rings, seeds and range trackers, and compares every response word
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module pot_average_range_tracker_unit_checker #(
   parameter int WINDOW = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   part_req_if       req_mon,
   part_rsp_if       rsp_mon,
   part_csr_if       csr_mon,
   output int        fail_count,
   output int        pending,
   output int        result_count,
   output int        tracked_count
);

   typedef struct packed {
      logic                          op;
      logic                          axis;
      logic [part_pkg::SAMPLE_W-1:0] sample;
      logic                          use_stored;
   } pot_word_type;

   typedef struct packed {
      logic                         axis_out;
      logic [part_pkg::VALUE_W-1:0] value;
      logic [part_pkg::VALUE_W-1:0] range_min;
      logic [part_pkg::VALUE_W-1:0] range_max;
      logic [part_pkg::VALUE_W-1:0] range_center;
      logic                         tracking;
   } pot_reading_type;

   logic [part_pkg::SEED_W-1:0]   x_low_seed, x_high_seed, y_low_seed, y_high_seed;
   logic [part_pkg::SAMPLE_W-1:0] ring [2][WINDOW];
   int unsigned                   slot [2];
   logic [part_pkg::VALUE_W-1:0]  low_q [2];
   logic [part_pkg::VALUE_W-1:0]  high_q [2];
   logic [part_pkg::VALUE_W-1:0]  center_q [2];
   int unsigned                   warmup;
   logic                          tracking_on;
   pot_reading_type               awaited_readings [$];

   function automatic pot_reading_type track_word(pot_word_type w);
      pot_reading_type r;
      int unsigned     sum;
      int unsigned     avg;
      int              a;
      r = '0;
      a = int'(w.axis);
      if (w.op == part_pkg::OP_RESTART) begin
         if (w.use_stored) begin
            low_q[part_pkg::AXIS_X]  = part_pkg::VALUE_W'(x_low_seed);
            high_q[part_pkg::AXIS_X] = part_pkg::VALUE_W'(x_high_seed);
            low_q[part_pkg::AXIS_Y]  = part_pkg::VALUE_W'(y_low_seed);
            high_q[part_pkg::AXIS_Y] = part_pkg::VALUE_W'(y_high_seed);
         end else begin
            low_q[part_pkg::AXIS_X]  = part_pkg::VALUE_W'(part_pkg::LOW_RESET);
            low_q[part_pkg::AXIS_Y]  = part_pkg::VALUE_W'(part_pkg::LOW_RESET);
            high_q[part_pkg::AXIS_X] = '0;
            high_q[part_pkg::AXIS_Y] = '0;
         end
      end else begin
         if (w.axis == part_pkg::AXIS_X) begin
            if (warmup >= 2 * WINDOW) begin
               warmup      = 0;
               tracking_on = 1'b1;
            end else begin
               warmup++;
            end
         end
         ring[a][slot[a]] = w.sample;
         slot[a] = (slot[a] + 1) % WINDOW;
         sum = 0;
         for (int i = 0; i < WINDOW; i++) sum += ring[a][i];
         avg = sum / WINDOW;
         if (avg == 0) avg = 1;
         r.value = part_pkg::VALUE_W'(part_pkg::VALUE_NUM / avg + part_pkg::VALUE_OFS);
         if (tracking_on) begin
            if (r.value > high_q[a]) high_q[a] = r.value;
            if (r.value < low_q[a]) low_q[a] = r.value;
            center_q[a] = part_pkg::VALUE_W'((int'(low_q[a]) + int'(high_q[a])) / 2);
         end
      end
      r.axis_out     = w.axis;
      r.range_min    = low_q[a];
      r.range_max    = high_q[a];
      r.range_center = center_q[a];
      r.tracking     = tracking_on;
      return r;
   endfunction

   function automatic void check_field(string field, logic [part_pkg::VALUE_W-1:0] want,
                                       logic [part_pkg::VALUE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      pot_word_type    word;
      pot_reading_type want;
      if (reset) begin
         x_low_seed  = '0;
         x_high_seed = '0;
         y_low_seed  = '0;
         y_high_seed = '0;
         for (int a = 0; a < 2; a++) begin
            for (int i = 0; i < WINDOW; i++) ring[a][i] = '0;
            slot[a]     = 0;
            low_q[a]    = part_pkg::VALUE_W'(part_pkg::LOW_RESET);
            high_q[a]   = '0;
            center_q[a] = '0;
         end
         warmup      = 0;
         tracking_on = 1'b0;
         awaited_readings.delete();
         pending = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               part_pkg::REG_X_LOW:  x_low_seed  = csr_mon.data;
               part_pkg::REG_X_HIGH: x_high_seed = csr_mon.data;
               part_pkg::REG_Y_LOW:  y_low_seed  = csr_mon.data;
               part_pkg::REG_Y_HIGH: y_high_seed = csr_mon.data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            word.op         = req_mon.op;
            word.axis       = req_mon.axis;
            word.sample     = req_mon.sample;
            word.use_stored = req_mon.use_stored;
            awaited_readings.push_back(track_word(word));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_readings.size() == 0) begin
               $error("response word with no prediction pending");
               fail_count++;
            end else begin
               want = awaited_readings.pop_front();
               check_field("axis_out", want.axis_out, rsp_mon.axis_out);
               check_field("value", want.value, rsp_mon.value);
               check_field("range_min", want.range_min, rsp_mon.range_min);
               check_field("range_max", want.range_max, rsp_mon.range_max);
               check_field("range_center", want.range_center, rsp_mon.range_center);
               check_field("tracking", want.tracking, rsp_mon.tracking);
               result_count++;
               if (want.tracking) tracked_count++;
            end
         end
         pending = awaited_readings.size();
      end
   end

endmodule

@@ dv/pot_average_range_tracker_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pot average range tracker testbench
// Drives directed and random sample/restart words with random gaps and
// response stalls, reprograms the seed registers between phases, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module pot_average_range_tracker_unit_test;

   localparam int WINDOW        = 8;
   localparam int PERIOD        = 10;
   localparam int RESET_CYCLES  = 11;
   localparam int WORD_TARGET   = 550;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 100;
   localparam int MAX_GAP       = 14;
   localparam int SAMPLE_W      = part_pkg::SAMPLE_W;
   localparam int SEED_W        = part_pkg::SEED_W;
   localparam int CSR_IDX_W     = part_pkg::CSR_IDX_W;
   localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
   localparam int SEED_MAX      = (1 << SEED_W) - 1;
   localparam int CSR_IDX_MAX   = (1 << CSR_IDX_W) - 1;

   localparam int STYLE_UNIFORM = 0;
   localparam int STYLE_EDGES   = 1;
   localparam int STYLE_HOLD    = 2;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   steady_flow = 1'b0;

   int words_sent;
   int restarts_sent;
   int csr_writes;
   int idle_cycles;
   int fail_count;
   int pending;
   int result_count;
   int tracked_count;

   logic [SAMPLE_W-1:0] held [2];

   part_req_if req_ch ();
   part_rsp_if rsp_ch ();
   part_csr_if csr_ch ();

   always #(PERIOD / 2) clock = ~clock;

   pot_average_range_tracker_unit #(
      .WINDOW (WINDOW)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   pot_average_range_tracker_unit_checker #(
      .WINDOW (WINDOW)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_mon       (csr_ch),
      .fail_count    (fail_count),
      .pending       (pending),
      .result_count  (result_count),
      .tracked_count (tracked_count)
   );

   function automatic int unsigned draw_gap();
      return steady_flow ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample(int style, logic axis);
      case (style)
         STYLE_EDGES: begin
            case ($urandom_range(0, 4))
               0: return '0;
               1: return SAMPLE_W'(SAMPLE_MAX);
               2: return SAMPLE_W'(1);
               3: return SAMPLE_W'(SAMPLE_MAX - 1);
               default: return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            endcase
         end
         STYLE_HOLD: begin
            if ($urandom_range(0, 7) == 0) begin
               case ($urandom_range(0, 2))
                  0: held[axis] = '0;
                  1: held[axis] = SAMPLE_W'(SAMPLE_MAX);
                  default: held[axis] = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
               endcase
            end
            return held[axis];
         end
         default: return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
      endcase
   endfunction

   function automatic logic [SEED_W-1:0] pick_seed(int phase);
      if (phase == 0) return SEED_W'(SEED_MAX);
      if (phase == 1) return '0;
      case ($urandom_range(0, 3))
         0: return '0;
         1: return SEED_W'(SEED_MAX);
         default: return SEED_W'($urandom_range(0, SEED_MAX));
      endcase
   endfunction

   // leaves valid high so the next word can follow without a bubble
   task automatic send_word(input logic op, input logic axis,
                            input logic [SAMPLE_W-1:0] smp, input logic stored);
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.op         <= op;
      req_ch.axis       <= axis;
      req_ch.sample     <= smp;
      req_ch.use_stored <= stored;
      req_ch.valid      <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      words_sent++;
      if (op == part_pkg::OP_RESTART) restarts_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [SEED_W-1:0] val);
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      csr_ch.valid <= 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_writes++;
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // response side
   initial begin
      int unsigned stall;
      rsp_ch.ready = 1'b0;
      forever begin
         stall = draw_gap();
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int          random_words;
      int          phase;
      int          style;
      int unsigned phase_len;
      logic        axis;
      req_ch.valid      = 1'b0;
      req_ch.op         = part_pkg::OP_SAMPLE;
      req_ch.axis       = part_pkg::AXIS_X;
      req_ch.sample     = '0;
      req_ch.use_stored = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = '0;
      csr_ch.data       = '0;
      held[part_pkg::AXIS_X] = '0;
      held[part_pkg::AXIS_Y] = '0;
      random_words      = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // reset seeds, both restart kinds, then warm-up through tracking on
      send_word(part_pkg::OP_RESTART, part_pkg::AXIS_Y, SAMPLE_W'(SAMPLE_MAX), 1'b1);
      send_word(part_pkg::OP_RESTART, part_pkg::AXIS_X, '0, 1'b0);
      send_word(part_pkg::OP_SAMPLE, part_pkg::AXIS_Y, SAMPLE_W'(SAMPLE_MAX), 1'b0);
      send_word(part_pkg::OP_SAMPLE, part_pkg::AXIS_Y, '0, 1'b1);
      for (int i = 0; i < 2 * WINDOW + 2; i++) begin
         send_word(part_pkg::OP_SAMPLE, part_pkg::AXIS_X,
                   (i == 0) ? '0 : (i % 3 == 1) ? SAMPLE_W'(SAMPLE_MAX) :
                   SAMPLE_W'(1 << (i % SAMPLE_W)), i[0]);
      end
      send_word(part_pkg::OP_SAMPLE, part_pkg::AXIS_Y, SAMPLE_W'(SAMPLE_MAX), 1'b0);
      send_word(part_pkg::OP_RESTART, part_pkg::AXIS_Y, '0, 1'b0);

      phase = 0;
      while (random_words < WORD_TARGET) begin
         drain_results();
         write_reg(part_pkg::REG_X_LOW, pick_seed(phase));
         write_reg(part_pkg::REG_X_HIGH, pick_seed(phase));
         write_reg(part_pkg::REG_Y_LOW, pick_seed(phase));
         write_reg(part_pkg::REG_Y_HIGH, pick_seed(phase));
         if (phase < 2 || $urandom_range(0, 2) == 0) begin
            write_reg(CSR_IDX_W'($urandom_range(int'(part_pkg::REG_Y_HIGH) + 1, CSR_IDX_MAX)),
                      SEED_W'($urandom_range(0, SEED_MAX)));
         end
         csr_ch.valid <= 1'b0;
         steady_flow = ($urandom_range(0, 3) == 0);
         style       = $urandom_range(STYLE_UNIFORM, STYLE_HOLD);
         phase_len   = $urandom_range(30, 70);
         if (random_words + int'(phase_len) > WORD_TARGET) begin
            phase_len = unsigned'(WORD_TARGET - random_words);
         end
         repeat (phase_len) begin
            axis = $urandom_range(0, 1) ? part_pkg::AXIS_Y : part_pkg::AXIS_X;
            if ($urandom_range(0, 15) == 0) begin
               send_word(part_pkg::OP_RESTART, axis, SAMPLE_W'($urandom_range(0, SAMPLE_MAX)),
                         1'($urandom_range(0, 1)));
            end else begin
               send_word(part_pkg::OP_SAMPLE, axis, pick_sample(style, axis),
                         1'($urandom_range(0, 1)));
            end
            random_words++;
         end
         phase++;
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d words sent (%0d restarts) over %0d seed phases, %0d register writes",
               words_sent, restarts_sent, phase, csr_writes);
      $display("%0d responses compared, %0d of them with range tracking on",
               result_count, tracked_count);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
